@@ hw/rtl/cps_pkg.sv @@
// Shared types and constants of the cycle profile statistics table.
package cps_pkg;

  localparam int unsigned OP_W       = 3;
  localparam int unsigned SLOT_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned TOTAL_W    = 48;
  localparam int unsigned SLOT_RANGE = 2 ** SLOT_W;
  localparam int unsigned DIV_STEPS  = DATA_W;

  localparam logic [DATA_W-1:0] CYCLES_ALL_ONES = '1;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD      = 3'd0,
    OP_REGISTER    = 3'd1,
    OP_CLEAR_SLOT  = 3'd2,
    OP_CLEAR_TOTAL = 3'd3,
    OP_CLEAR_ALL   = 3'd4,
    OP_QUERY       = 3'd5
  } opcode_e;

  typedef struct packed {
    logic [DATA_W-1:0] min_cycles;
    logic [DATA_W-1:0] max_cycles;
    logic [DATA_W-1:0] mean_cycles;
    logic [DATA_W-1:0] run_count;
  } stat_t;

  localparam stat_t STAT_EMPTY = '{
    min_cycles:  CYCLES_ALL_ONES,
    max_cycles:  '0,
    mean_cycles: '0,
    run_count:   '0
  };

  typedef struct packed {
    logic                status;
    logic [SLOT_W-1:0]   slot_out;
    stat_t               stats;
    logic [TOTAL_W-1:0]  total_cycles;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic rd;
    logic exec;
    logic mul;
    logic div_start;
    logic div_step;
    logic wb;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_record;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/cps_req_if.sv @@
// Request channel of the cycle profile statistics table.
interface cps_req_if;
  import cps_pkg::*;

  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [SLOT_W-1:0]   slot_index;
  logic [DATA_W-1:0]   elapsed_cycles;

  modport source (output valid, output opcode, output slot_index, output elapsed_cycles,
                  input ready);
  modport sink   (input valid, input opcode, input slot_index, input elapsed_cycles,
                  output ready);
endinterface

@@ hw/rtl/cps_rsp_if.sv @@
// Response channel of the cycle profile statistics table.
interface cps_rsp_if;
  import cps_pkg::*;

  logic                valid;
  logic                ready;
  logic                status;
  logic [SLOT_W-1:0]   slot_out;
  logic [DATA_W-1:0]   min_cycles;
  logic [DATA_W-1:0]   max_cycles;
  logic [DATA_W-1:0]   mean_cycles;
  logic [DATA_W-1:0]   run_count;
  logic [TOTAL_W-1:0]  total_cycles;

  modport source (output valid, output status, output slot_out, output min_cycles,
                  output max_cycles, output mean_cycles, output run_count,
                  output total_cycles, input ready);
  modport sink   (input valid, input status, input slot_out, input min_cycles,
                  input max_cycles, input mean_cycles, input run_count,
                  input total_cycles, output ready);
endinterface

@@ hw/rtl/cps_ctrl.sv @@
// Controller state machine that sequences one request through the datapath.
module cps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  cps_pkg::sts_t   sts_i,
  output cps_pkg::cmd_t   cmd_o
);
  import cps_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_READ   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_MUL    = 7'b0001000,
    ST_DSTART = 7'b0010000,
    ST_DIV    = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   wb_pending;

  assign req_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    wb_pending = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_record ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DSTART;
      end
      ST_DSTART: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        // The write-back happens in the cycle that sees the quotient complete.
        wb_pending = sts_i.div_done;
        if (wb_pending) begin
          cmd_o.wb = 1'b1;
          state_d  = ST_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/cps_divider.sv @@
// Restoring divider that yields one quotient bit per step.
module cps_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            step_i,
  input  logic [2*cps_pkg::DATA_W-1:0]    dividend_i,
  input  logic [cps_pkg::DATA_W:0]        divisor_i,
  output logic [cps_pkg::DATA_W-1:0]      quotient_o,
  output logic                            done_o
);
  import cps_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_STEPS + 1);

  logic [DATA_W:0]   rem_q, dsr_q;
  logic [DATA_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [DATA_W+1:0] shifted, diff;
  logic              ge;

  // The caller guarantees that the quotient fits in DATA_W bits, so the
  // upper half of the dividend is already below the divisor.
  assign shifted    = {rem_q, quo_q[DATA_W-1]};
  assign ge         = (shifted >= {1'b0, dsr_q});
  assign diff       = shifted - {1'b0, dsr_q};
  assign quotient_o = quo_q;
  assign done_o     = (cnt_q == CNT_W'(DIV_STEPS));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i[2*DATA_W-1:DATA_W]};
      quo_q <= dividend_i[DATA_W-1:0];
      dsr_q <= divisor_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[DATA_W:0] : shifted[DATA_W:0];
      quo_q <= {quo_q[DATA_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

endmodule

@@ hw/rtl/cps_datapath.sv @@
// Slot table storage, statistics update arithmetic and response register.
module cps_datapath #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cps_pkg::cmd_t                 cmd_i,
  output cps_pkg::sts_t                 sts_o,
  input  logic [cps_pkg::OP_W-1:0]      req_opcode_i,
  input  logic [cps_pkg::SLOT_W-1:0]    req_slot_index_i,
  input  logic [cps_pkg::DATA_W-1:0]    req_elapsed_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output cps_pkg::rsp_t                 rsp_o
);
  import cps_pkg::*;

  // Only the slots that a request can address need storage; registered slots
  // beyond that range always read as empty.
  localparam int unsigned STORE  = (NUM_SLOTS < SLOT_RANGE) ? NUM_SLOTS : SLOT_RANGE;
  localparam int unsigned ADDR_W = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);

  stat_t              stat_mem [STORE];
  logic [TOTAL_W-1:0] tot_mem  [STORE];

  logic [STORE-1:0]   ent_vld_q, ent_vld_d;
  logic [STORE-1:0]   tot_vld_q, tot_vld_d;
  logic [CNT_W-1:0]   reg_cnt_q, reg_cnt_d;

  logic [OP_W-1:0]    op_q;
  logic [DATA_W-1:0]  elapsed_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [SLOT_W-1:0]  slot_out_q, slot_out_d;
  logic               hit_q, hit_d;
  logic               full_q, full_now;

  stat_t              rd_ent_q, cur_ent, new_ent;
  logic [TOTAL_W-1:0] rd_tot_q, cur_tot, new_tot;
  logic [2*DATA_W-1:0] prod_q, dividend;
  logic [DATA_W:0]    divisor;
  logic [DATA_W-1:0]  quotient;
  logic               div_done;

  rsp_t               res_q, res_d, out_q;
  logic               out_vld_q;

  // Request decode at acceptance.
  always_comb begin
    full_now = (32'(reg_cnt_q) >= NUM_SLOTS);
    if (req_opcode_i == OP_REGISTER) begin
      hit_d      = !full_now && (32'(reg_cnt_q) < STORE);
      addr_d     = ADDR_W'(reg_cnt_q);
      slot_out_d = full_now ? '0 : SLOT_W'(reg_cnt_q);
    end else begin
      hit_d      = (32'(req_slot_index_i) < NUM_SLOTS);
      addr_d     = ADDR_W'(req_slot_index_i);
      slot_out_d = req_slot_index_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= req_opcode_i;
      elapsed_q  <= req_elapsed_i;
      addr_q     <= addr_d;
      slot_out_q <= slot_out_d;
      hit_q      <= hit_d;
      full_q     <= (req_opcode_i == OP_REGISTER) && full_now;
    end
  end

  // Table memories: one read port, one write port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wb) begin
      stat_mem[addr_q] <= new_ent;
      tot_mem[addr_q]  <= new_tot;
    end
    if (cmd_i.rd) begin
      rd_ent_q <= stat_mem[addr_q];
      rd_tot_q <= tot_mem[addr_q];
    end
  end

  assign cur_ent = ent_vld_q[addr_q] ? rd_ent_q : STAT_EMPTY;
  assign cur_tot = tot_vld_q[addr_q] ? rd_tot_q : '0;

  // Record update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= (2*DATA_W)'(cur_ent.mean_cycles) * (2*DATA_W)'(cur_ent.run_count);
    end
  end

  assign dividend = prod_q + (2*DATA_W)'(elapsed_q);
  assign divisor  = {1'b0, cur_ent.run_count} + (DATA_W+1)'(1);

  cps_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  always_comb begin
    new_ent.min_cycles  = (elapsed_q < cur_ent.min_cycles) ? elapsed_q : cur_ent.min_cycles;
    new_ent.max_cycles  = (elapsed_q > cur_ent.max_cycles) ? elapsed_q : cur_ent.max_cycles;
    new_ent.mean_cycles = quotient;
    new_ent.run_count   = (cur_ent.run_count == CYCLES_ALL_ONES) ? cur_ent.run_count
                                                                 : cur_ent.run_count + DATA_W'(1);
    new_tot             = cur_tot + TOTAL_W'(elapsed_q);
  end

  // Valid bits and registry count.
  always_comb begin
    ent_vld_d = ent_vld_q;
    tot_vld_d = tot_vld_q;
    reg_cnt_d = reg_cnt_q;
    if (cmd_i.exec) begin
      case (op_q)
        OP_REGISTER: begin
          if (!full_q) begin
            reg_cnt_d = reg_cnt_q + CNT_W'(1);
          end
        end
        OP_CLEAR_SLOT: begin
          if (hit_q) begin
            ent_vld_d[addr_q] = 1'b0;
            tot_vld_d[addr_q] = 1'b0;
          end
        end
        OP_CLEAR_TOTAL: begin
          if (hit_q) begin
            tot_vld_d[addr_q] = 1'b0;
          end
        end
        OP_CLEAR_ALL: begin
          for (int i = 0; i < STORE; i++) begin
            if (32'(i) < 32'(reg_cnt_q)) begin
              tot_vld_d[i] = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.wb) begin
      ent_vld_d[addr_q] = 1'b1;
      tot_vld_d[addr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      tot_vld_q <= '0;
      reg_cnt_q <= '0;
    end else begin
      ent_vld_q <= ent_vld_d;
      tot_vld_q <= tot_vld_d;
      reg_cnt_q <= reg_cnt_d;
    end
  end

  // Response staging.
  always_comb begin
    res_d          = res_q;
    res_d.status   = full_q;
    res_d.slot_out = slot_out_q;
    if (cmd_i.wb) begin
      res_d.stats        = new_ent;
      res_d.total_cycles = new_tot;
    end else begin
      res_d.stats        = hit_q ? cur_ent : STAT_EMPTY;
      res_d.total_cycles = hit_q ? cur_tot : '0;
      case (op_q)
        OP_CLEAR_SLOT: begin
          res_d.stats        = STAT_EMPTY;
          res_d.total_cycles = '0;
        end
        OP_CLEAR_TOTAL: begin
          res_d.total_cycles = '0;
        end
        OP_CLEAR_ALL: begin
          if (32'(addr_q) < 32'(reg_cnt_q)) begin
            res_d.total_cycles = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec || cmd_i.wb) begin
      res_q <= res_d;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign rsp_valid_o     = out_vld_q;
  assign rsp_o           = out_q;
  assign sts_o.is_record = (op_q == OP_RECORD) && hit_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_busy  = out_vld_q && !rsp_ready_i;

endmodule

@@ hw/rtl/cycle_profile_stats_table.sv @@
// The block takes one request at a time and accepts the next only once the last has
// been sequenced through. A record takes longest: its time is set by the 32-step
// restoring divider that forms the running mean.
// A finished response waits in an output register while the next request is taken.
// Reset (asynchronous, active low) clears the per-slot valid bits and the registry
// count at once, so every slot reads as empty without a clearing pass.
module cycle_profile_stats_table #(
  parameter int unsigned NUM_SLOTS = 32
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cps_req_if.sink   req_i,
  cps_rsp_if.source rsp_o
);
  import cps_pkg::*;

  // The controller owns the request handshake and walks each request through
  // read, execute and, for a record, multiply, divide and write-back.
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic rsp_valid;

  cps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the slot table, the registry count, the mean
  // arithmetic and the output register that drives the response channel.
  cps_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_opcode_i     (req_i.opcode),
    .req_slot_index_i (req_i.slot_index),
    .req_elapsed_i    (req_i.elapsed_cycles),
    .rsp_valid_o      (rsp_valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_o            (rsp)
  );

  // Unpack the response onto the channel fields.
  assign rsp_o.valid        = rsp_valid;
  assign rsp_o.status       = rsp.status;
  assign rsp_o.slot_out     = rsp.slot_out;
  assign rsp_o.min_cycles   = rsp.stats.min_cycles;
  assign rsp_o.max_cycles   = rsp.stats.max_cycles;
  assign rsp_o.mean_cycles  = rsp.stats.mean_cycles;
  assign rsp_o.run_count    = rsp.stats.run_count;
  assign rsp_o.total_cycles = rsp.total_cycles;

endmodule

@@ tb/cycle_profile_stats_table_tb.sv @@
// Self-checking testbench for the cycle profile statistics table.
module cycle_profile_stats_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cps_pkg::*;

  localparam int unsigned NUM_SLOTS     = 32;
  localparam int unsigned RANDOM_OPS    = 550;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // The opcode field has two encodings beyond the defined operations. The
  // block must treat both of them as a query.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // One request as the stimulus sees it. The wait_idle flag holds the request
  // back until every response of the earlier requests has been collected.
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] elapsed;
    bit                wait_idle;
  } profile_op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  cps_req_if req_if ();
  cps_rsp_if rsp_if ();

  cycle_profile_stats_table #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the statistics table, updated as each request is accepted.
  logic [DATA_W-1:0]  tbl_min   [NUM_SLOTS];
  logic [DATA_W-1:0]  tbl_max   [NUM_SLOTS];
  logic [DATA_W-1:0]  tbl_mean  [NUM_SLOTS];
  logic [DATA_W-1:0]  tbl_runs  [NUM_SLOTS];
  logic [TOTAL_W-1:0] tbl_total [NUM_SLOTS];
  int unsigned        reg_count;

  profile_op_t pending_ops[$];
  rsp_t        awaited_stats[$];
  profile_op_t cur_op;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Sender burst shaping and receiver stall pattern.
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] rdy_pattern;
  int unsigned rdy_epoch;

  function automatic void clear_profile(input int unsigned s);
    tbl_min[s]   = CYCLES_ALL_ONES;
    tbl_max[s]   = '0;
    tbl_mean[s]  = '0;
    tbl_runs[s]  = '0;
    tbl_total[s] = '0;
  endfunction

  // Applies one request to the shadow table and returns the response that the
  // block has to give for it.
  function automatic rsp_t apply_profile_op(input profile_op_t p);
    rsp_t              r;
    int unsigned       s;
    logic [63:0]       sum;
    logic [DATA_W:0]   divisor;
    s          = 32'(p.slot);
    r.status   = 1'b0;
    r.slot_out = p.slot;
    case (p.op)
      OP_RECORD: begin
        if (p.elapsed < tbl_min[s]) tbl_min[s] = p.elapsed;
        if (p.elapsed > tbl_max[s]) tbl_max[s] = p.elapsed;
        // The product of a 32-bit mean and a 32-bit run count plus one more
        // 32-bit value always fits in 64 bits. The divisor needs 33 bits
        // once the run count has saturated.
        sum       = {32'd0, tbl_mean[s]} * {32'd0, tbl_runs[s]} + {32'd0, p.elapsed};
        divisor   = {1'b0, tbl_runs[s]} + 33'd1;
        tbl_mean[s] = DATA_W'(sum / {31'd0, divisor});
        if (tbl_runs[s] != CYCLES_ALL_ONES) tbl_runs[s] = tbl_runs[s] + 32'd1;
        tbl_total[s] = tbl_total[s] + {16'd0, p.elapsed};
      end
      OP_REGISTER: begin
        if (reg_count >= NUM_SLOTS) begin
          // A full registry answers with an empty slot and no slot number.
          r.status       = 1'b1;
          r.slot_out     = '0;
          r.stats        = STAT_EMPTY;
          r.total_cycles = '0;
          return r;
        end
        // A slot handed out keeps whatever it already holds.
        s          = reg_count;
        reg_count  = reg_count + 1;
        r.slot_out = SLOT_W'(s);
      end
      OP_CLEAR_SLOT:  clear_profile(s);
      OP_CLEAR_TOTAL: tbl_total[s] = '0;
      OP_CLEAR_ALL: begin
        // Only the registered slots lose their totals; the response still
        // reports the addressed slot, registered or not.
        for (int unsigned i = 0; i < reg_count; i++) tbl_total[i] = '0;
      end
      default: ;
    endcase
    r.stats.min_cycles  = tbl_min[s];
    r.stats.max_cycles  = tbl_max[s];
    r.stats.mean_cycles = tbl_mean[s];
    r.stats.run_count   = tbl_runs[s];
    r.total_cycles      = tbl_total[s];
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [TOTAL_W-1:0] want,
                                      input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic push_op(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                         input logic [DATA_W-1:0] elapsed, input bit wait_idle);
    profile_op_t p;
    p.op        = op;
    p.slot      = slot;
    p.elapsed   = elapsed;
    p.wait_idle = wait_idle;
    pending_ops.push_back(p);
  endtask

  // Most traffic goes to a handful of hot slots so that run counts and means
  // build up over many records; the rest spreads over the whole table.
  function automatic logic [SLOT_W-1:0] pick_slot();
    if ($urandom_range(0, 3) != 0) return SLOT_W'($urandom_range(0, 5));
    return SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return CYCLES_ALL_ONES;
      2, 3:    return DATA_W'($urandom_range(0, 1000));
      4:       return CYCLES_ALL_ONES - DATA_W'($urandom_range(0, 1000));
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return OP_RECORD;
    if (roll < 65) return OP_QUERY;
    if (roll < 73) return OP_REGISTER;
    if (roll < 78) return OP_CLEAR_SLOT;
    if (roll < 85) return OP_CLEAR_TOTAL;
    if (roll < 92) return OP_CLEAR_ALL;
    if (roll < 96) return OP_SPARE_6;
    return OP_SPARE_7;
  endfunction

  // Request driver. A request stays on the bus unchanged until the block takes
  // it. Requests go out in bursts of random length separated by random gaps;
  // a gap of zero lets bursts run back to back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid          <= 1'b0;
      req_if.opcode         <= '0;
      req_if.slot_index     <= '0;
      req_if.elapsed_cycles <= '0;
      burst_left = $urandom_range(1, 16);
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        awaited_stats.push_back(apply_profile_op(cur_op));
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_if.valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].wait_idle && awaited_stats.size() != 0)) begin
          cur_op = pending_ops.pop_front();
          req_if.valid          <= 1'b1;
          req_if.opcode         <= cur_op.op;
          req_if.slot_index     <= cur_op.slot;
          req_if.elapsed_cycles <= cur_op.elapsed;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor. Each accepted response is checked against the oldest
  // outstanding prediction. Ready follows a rotating 16-bit pattern that is
  // redrawn each time the epoch counter wraps: always ready, random, mostly ready,
  // or a lone ready bit in the pattern for long stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      rdy_pattern = 16'hFFFF;
      rdy_epoch   = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_stats.size() == 0) begin
          $display("%0t: response with none outstanding, slot %0d", $time, rsp_if.slot_out);
          error_count++;
        end else begin
          rsp_t want;
          want = awaited_stats.pop_front();
          check_field("status", TOTAL_W'(want.status), TOTAL_W'(rsp_if.status));
          check_field("slot_out", TOTAL_W'(want.slot_out), TOTAL_W'(rsp_if.slot_out));
          check_field("min_cycles", TOTAL_W'(want.stats.min_cycles),
                      TOTAL_W'(rsp_if.min_cycles));
          check_field("max_cycles", TOTAL_W'(want.stats.max_cycles),
                      TOTAL_W'(rsp_if.max_cycles));
          check_field("mean_cycles", TOTAL_W'(want.stats.mean_cycles),
                      TOTAL_W'(rsp_if.mean_cycles));
          check_field("run_count", TOTAL_W'(want.stats.run_count),
                      TOTAL_W'(rsp_if.run_count));
          check_field("total_cycles", want.total_cycles, rsp_if.total_cycles);
        end
      end
      rdy_epoch++;
      if (rdy_epoch == 200) begin
        rdy_epoch = 0;
        case ($urandom_range(0, 3))
          0:       rdy_pattern = 16'hFFFF;
          1:       rdy_pattern = 16'($urandom);
          2:       rdy_pattern = 16'($urandom) | 16'($urandom);
          default: rdy_pattern = 16'h0001;
        endcase
        if (rdy_pattern == '0) rdy_pattern = 16'h0001;
      end else begin
        rdy_pattern = {rdy_pattern[14:0], rdy_pattern[15]};
      end
      rsp_if.ready <= rdy_pattern[0];
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles", $time, CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    for (int unsigned i = 0; i < NUM_SLOTS; i++) clear_profile(i);
    reg_count = 0;

    // Directed part: empty slots at both ends of the table, registration of
    // the first slots, records at the value extremes, an unregistered slot,
    // every clear flavor, and both spare opcodes.
    push_op(OP_QUERY,       5'd0,  '0,              1'b0);
    push_op(OP_QUERY,       5'd31, CYCLES_ALL_ONES, 1'b0);
    push_op(OP_REGISTER,    5'd17, '0,              1'b0);
    push_op(OP_REGISTER,    5'd31, '0,              1'b0);
    push_op(OP_RECORD,      5'd0,  '0,              1'b0);
    push_op(OP_RECORD,      5'd0,  CYCLES_ALL_ONES, 1'b0);
    push_op(OP_RECORD,      5'd0,  32'd1,           1'b0);
    push_op(OP_RECORD,      5'd31, CYCLES_ALL_ONES, 1'b0);
    push_op(OP_RECORD,      5'd31, CYCLES_ALL_ONES, 1'b0);
    push_op(OP_RECORD,      5'd1,  32'h8000_0000,   1'b0);
    push_op(OP_RECORD,      5'd1,  32'h7FFF_FFFF,   1'b0);
    push_op(OP_CLEAR_TOTAL, 5'd0,  '0,              1'b0);
    push_op(OP_QUERY,       5'd0,  '0,              1'b0);
    push_op(OP_RECORD,      5'd0,  32'd12345,       1'b0);
    // Only slots 0 and 1 are registered here, so slot 31 keeps its total.
    push_op(OP_CLEAR_ALL,   5'd31, '0,              1'b0);
    push_op(OP_QUERY,       5'd0,  '0,              1'b0);
    push_op(OP_QUERY,       5'd31, '0,              1'b0);
    push_op(OP_CLEAR_SLOT,  5'd1,  '0,              1'b0);
    push_op(OP_QUERY,       5'd1,  '0,              1'b0);
    push_op(OP_SPARE_6,     5'd0,  CYCLES_ALL_ONES, 1'b0);
    push_op(OP_SPARE_7,     5'd31, '0,              1'b0);
    push_op(OP_REGISTER,    5'd0,  '0,              1'b0);
    push_op(OP_CLEAR_SLOT,  5'd31, '0,              1'b0);
    push_op(OP_QUERY,       5'd31, '0,              1'b0);

    // Random part. Registers are spread through the run, so clear-all sees
    // many registry sizes before the registry fills and later registers are
    // refused. Twice the sender holds off until the block has answered
    // everything outstanding.
    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      push_op(pick_op(), pick_slot(), pick_elapsed(), i == 0 || i == RANDOM_OPS / 2);
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sampled away from the active edge so that the driver's updates have settled.
    while (pending_ops.size() != 0 || req_if.valid || awaited_stats.size() != 0) begin
      @(negedge clk_i);
    end
    // Longer than the record latency, so a stray extra response gets caught.
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
